// ===== src/tcp_stream_reassembler_assert.svh =====
// Assertion macros shared by the reassembler RTL.
// Needs only a clock and an active-low reset at the point of use.
`ifndef TCP_STREAM_REASSEMBLER_ASSERT_SVH
`define TCP_STREAM_REASSEMBLER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TSR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tsr_pkg.sv =====
// Package for the TCP stream reassembler: item types and shared constants.
// No dependencies.
package tsr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CNT_W        = 7;   // width of the count fields of a result item

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        segment_end;
    logic        eof_flag;
  } in_item_t;

  typedef struct packed {
    logic             read_valid;
    logic [7:0]       read_byte;
    logic [31:0]      next_expected;
    logic [CNT_W-1:0] unassembled_count;
    logic [CNT_W-1:0] buffered_count;
    logic             input_ended;
  } out_item_t;

endpackage

// ===== src/tsr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/tcp_stream_reassembler.sv =====
// Top level of the TCP stream reassembler: byte ring, valid bitmap, ack scan.
// Depends on tsr_pkg, tsr_ram and tcp_stream_reassembler_assert.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | in_valid_i  / in_ready_o   | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i  | out_item_o (out_item_t)
//
// A pop, or a push that stores nothing, goes from accept through S_EXEC and S_EMIT
// to the output register. A push that stores a byte also passes through S_SCAN,
// where the ack scan walks the valid bitmap one slot per cycle over the bytes it assembles.
// One item is in work at a time; in_ready_o is high only between items.
// The result waits in an output register; a stalled consumer holds the block
// in its emit state until the register frees up.
// Reset clears the bitmap, pointers, counts and flags at once; the byte ring
// needs no clearing since a pop only reads slots that were written.
`include "tcp_stream_reassembler_assert.svh"

module tcp_stream_reassembler #(
  parameter int CAPACITY = tsr_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsr_pkg::out_item_t out_item_o
);

  import tsr_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // slot index width
  localparam int PW = $clog2(CAPACITY + 1);                   // count width
  localparam logic [SW-1:0] SLOT_LAST = SW'(CAPACITY - 1);
  localparam logic [SW:0]   SLOT_SPAN = (SW + 1)'(CAPACITY);
  localparam logic [PW-1:0] CNT_FULL  = PW'(CAPACITY);
  localparam logic [31:0]   CAP_32    = 32'(CAPACITY);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;  // ring read data ready; pop or store
  localparam logic [1:0] S_SCAN = 2'd2;  // advance the ack one slot per cycle
  localparam logic [1:0] S_EMIT = 2'd3;  // hand the result to the output register

  logic [1:0]          state_q, state_d;
  in_item_t            item_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [31:0]         expected_q, expected_d;
  logic [31:0]         read_pos_q, read_pos_d;
  logic [SW-1:0]       head_q, head_d;       // slot of read_pos
  logic [SW-1:0]       exp_slot_q, exp_slot_d;  // slot of next_expected
  logic [PW-1:0]       buf_cnt_q, buf_cnt_d;  // next_expected - read_pos
  logic [PW-1:0]       pend_q, pend_d;       // unassembled bytes held
  logic                eof_q, eof_d;
  logic                ended_q, ended_d;
  logic                res_valid_q, res_valid_d;
  logic [7:0]          res_byte_q, res_byte_d;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                in_acc;
  logic                emit_go;
  logic [7:0]          ring_rdata;
  logic                ring_we;
  logic [SW-1:0]       wslot;

  // push decode
  logic [31:0]         off;
  logic [31:0]         buffered32;
  logic                is_old;
  logic                in_win;
  logic                fits;
  logic                do_write;
  logic [SW:0]         wsum;
  logic [CNT_W+PW-1:0] pend_ext;
  logic [CNT_W+PW-1:0] buf_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign buffered32 = 32'(buf_cnt_q);
  assign off        = item_q.stream_index - read_pos_q;
  assign is_old     = (item_q.stream_index < expected_q) || (off < buffered32);
  assign in_win     = off < CAP_32;
  assign fits       = item_q.has_byte ? (is_old || in_win)
                    : ((item_q.stream_index <= expected_q) || (off <= CAP_32));
  assign do_write   = item_q.has_byte && !is_old && in_win;
  // off is below CAPACITY whenever it is used as a slot offset
  assign wsum       = {1'b0, head_q} + {1'b0, off[SW-1:0]};
  assign wslot      = (wsum >= SLOT_SPAN) ? SW'(wsum - SLOT_SPAN) : wsum[SW-1:0];
  assign ring_we    = (state_q == S_EXEC) && (item_q.action == ACT_PUSH) && do_write;

  tsr_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wslot),
    .wdata_i (item_q.data_byte),
    .re_i    (in_acc),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    expected_d  = expected_q;
    read_pos_d  = read_pos_q;
    head_d      = head_q;
    exp_slot_d  = exp_slot_q;
    buf_cnt_d   = buf_cnt_q;
    pend_d      = pend_q;
    eof_d       = eof_q;
    ended_d     = ended_q;
    res_valid_d = res_valid_q;
    res_byte_d  = res_byte_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_valid_d = 1'b0;
        res_byte_d  = '0;
        if (item_q.action == ACT_POP) begin
          if (buf_cnt_q != '0) begin
            res_valid_d = 1'b1;
            res_byte_d  = ring_rdata;
            head_d      = (head_q == SLOT_LAST) ? '0 : head_q + SW'(1);
            read_pos_d  = read_pos_q + 32'd1;
            buf_cnt_d   = buf_cnt_q - PW'(1);
          end
          state_d = S_EMIT;
        end else begin
          if (do_write) begin
            if (!valid_q[wslot]) begin
              valid_d[wslot] = 1'b1;
              pend_d         = pend_q + PW'(1);
            end
            state_d = S_SCAN;
          end else begin
            state_d = S_EMIT;
          end
          if (item_q.segment_end && item_q.eof_flag && fits) begin
            eof_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if ((buf_cnt_q >= CNT_FULL) || !valid_q[exp_slot_q]) begin
          state_d = S_EMIT;
        end else begin
          valid_d[exp_slot_q] = 1'b0;
          expected_d = expected_q + 32'd1;
          exp_slot_d = (exp_slot_q == SLOT_LAST) ? '0 : exp_slot_q + SW'(1);
          buf_cnt_d  = buf_cnt_q + PW'(1);
          if (pend_q != '0) begin
            pend_d = pend_q - PW'(1);
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          ended_d = ended_q || (eof_q && (pend_q == '0));
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // counts are reported modulo 2^CNT_W
  assign pend_ext = {{CNT_W{1'b0}}, pend_q};
  assign buf_ext  = {{CNT_W{1'b0}}, buf_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      expected_q  <= '0;
      read_pos_q  <= '0;
      head_q      <= '0;
      exp_slot_q  <= '0;
      buf_cnt_q   <= '0;
      pend_q      <= '0;
      eof_q       <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      expected_q <= expected_d;
      read_pos_q <= read_pos_d;
      head_q     <= head_d;
      exp_slot_q <= exp_slot_d;
      buf_cnt_q  <= buf_cnt_d;
      pend_q     <= pend_d;
      eof_q      <= eof_d;
      ended_q    <= ended_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    res_valid_q <= res_valid_d;
    res_byte_q  <= res_byte_d;
    if (emit_go) begin
      out_q.read_valid        <= res_valid_q;
      out_q.read_byte         <= res_byte_q;
      out_q.next_expected     <= expected_q;
      out_q.unassembled_count <= pend_ext[CNT_W-1:0];
      out_q.buffered_count    <= buf_ext[CNT_W-1:0];
      out_q.input_ended       <= ended_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // assertions
  `TSR_ASSERT_ALWAYS(a_buf_matches_ptrs, clk_i, rst_ni,
    (expected_q - read_pos_q) == 32'(buf_cnt_q), "buffered count out of step with pointers")
  `TSR_ASSERT_IMPL(a_scan_in_window, clk_i, rst_ni, state_q == S_SCAN,
    buf_cnt_q <= CNT_FULL, "ack scan ran past the window")
  `TSR_ASSERT_NEXT(a_pop_moves_read, clk_i, rst_ni,
    (state_q == S_EXEC) && (item_q.action == ACT_POP) && (buf_cnt_q != '0),
    read_pos_q == $past(read_pos_q) + 32'd1, "pop did not advance read position")
  `TSR_ASSERT_NEXT(a_ended_sticky, clk_i, rst_ni, ended_q, ended_q,
    "input_ended dropped")
  `TSR_ASSERT_NEXT(a_accept_execs, clk_i, rst_ni, in_acc, state_q == S_EXEC,
    "accepted item did not start execution")

endmodule
